// ----- hdl/iut_pkg.sv -----
// Shared types, sizes and codes for the interval union table.
package iut_pkg;

    localparam int MAX_RANGES = 64;
    localparam int ADDR_W     = 64;
    localparam int RIDX_W     = 6;
    localparam int COUNT_W    = 7;
    localparam int IDX_W      = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);
    localparam int CMP_W      = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;

    // command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_BAD_INDEX = 2'd3;

    typedef struct packed {
        logic [1:0]        command;
        logic [ADDR_W-1:0] range_start;
        logic [ADDR_W-1:0] range_end_excl;
        logic [RIDX_W-1:0] read_index;
    } t_iut_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [COUNT_W-1:0] range_count;
        logic [ADDR_W-1:0]  entry_lower;
        logic [ADDR_W-1:0]  entry_upper;
    } t_iut_rsp;

    typedef struct packed {
        logic [ADDR_W-1:0] lower;
        logic [ADDR_W-1:0] upper;
    } t_iut_entry;

    // controller -> datapath
    typedef struct packed {
        logic       capture;
        logic       clear;
        logic       prep;
        logic       scan;
        logic       plan;
        logic       move;
        logic       write;
        logic       load_out;
        logic [1:0] status;
        logic       show_entry;
    } t_iut_cmd;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic scan_done;
        logic full;
        logic move_done;
        logic idx_ok;
    } t_iut_sts;

endpackage

// ----- hdl/iut_dpath.sv -----
// Datapath: range table memory, scan/merge accumulators, shift engine, result register.
module iut_dpath import iut_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_iut_req i_req,
    input  t_iut_cmd i_ctl,
    output t_iut_sts o_sts,
    output t_iut_rsp o_rsp
);

    t_iut_entry r_mem [MAX_RANGES];
    t_iut_entry r_rdata;

    logic [ADDR_W-1:0] r_start, r_end, r_lo_m1, r_acc_lo, r_acc_hi;
    logic [RIDX_W-1:0] r_ridx;
    logic [CNT_W-1:0]  r_count, r_first, r_nmerge, r_ptr, r_left, r_gone;
    logic [IDX_W-1:0]  r_src, r_waddr;
    logic              r_pv, r_wv, r_up;
    t_iut_rsp          r_rsp;

    logic [CNT_W-1:0]  n_count, n_first, n_nmerge, n_ptr, n_left;
    logic [ADDR_W-1:0] n_acc_lo, n_acc_hi;
    logic [IDX_W-1:0]  n_src, n_waddr;
    logic              n_pv, n_wv;

    logic              w_below, w_above, w_merge, w_up;
    logic [IDX_W-1:0]  w_raddr, w_waddr;
    t_iut_entry        w_wdata;
    logic              w_we;

    // entry lies below the new range with a gap; start of zero has nothing below
    assign w_below = (r_start != '0) && (r_rdata.upper < r_lo_m1);
    // entry lies above with a gap; the inclusive top plus one is the exclusive end
    assign w_above = r_rdata.lower > r_end;
    assign w_merge = !w_below && !w_above;
    assign w_up    = (r_nmerge == '0);

    assign w_raddr = i_ctl.scan ? r_ptr[IDX_W-1:0] :
                     i_ctl.move ? r_src : IDX_W'(r_ridx);

    assign w_we    = r_wv || i_ctl.write;
    assign w_waddr = r_wv ? r_waddr : r_first[IDX_W-1:0];
    always_comb begin
        if (r_wv) begin
            w_wdata = r_rdata;
        end else begin
            w_wdata.lower = r_acc_lo;
            w_wdata.upper = r_acc_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    assign o_sts.empty     = (r_end <= r_start);
    assign o_sts.scan_done = (r_ptr == r_count) && !r_pv;
    assign o_sts.full      = w_up && (r_count >= CNT_W'(MAX_RANGES));
    assign o_sts.move_done = (r_left == '0) && !r_wv;
    assign o_sts.idx_ok    = (CMP_W'(r_ridx) < CMP_W'(r_count)) &&
                             (CMP_W'(r_ridx) < CMP_W'(MAX_RANGES));

    // scan step, shift step and move planning
    always_comb begin
        n_first  = r_first;
        n_nmerge = r_nmerge;
        n_acc_lo = r_acc_lo;
        n_acc_hi = r_acc_hi;
        n_ptr    = r_ptr;
        n_pv     = 1'b0;
        n_src    = r_src;
        n_left   = r_left;
        n_wv     = 1'b0;
        n_waddr  = r_waddr;
        if (i_ctl.scan) begin
            if (r_ptr != r_count) begin
                n_ptr = r_ptr + 1'b1;
                n_pv  = 1'b1;
            end
            if (r_pv) begin
                if (w_below) begin
                    n_first = r_first + 1'b1;
                end else if (w_merge) begin
                    n_nmerge = r_nmerge + 1'b1;
                    if (r_rdata.lower < r_acc_lo) begin
                        n_acc_lo = r_rdata.lower;
                    end
                    if (r_rdata.upper > r_acc_hi) begin
                        n_acc_hi = r_rdata.upper;
                    end
                end
            end
        end
        if (i_ctl.move && (r_left != '0)) begin
            n_src   = r_up ? r_src - 1'b1 : r_src + 1'b1;
            n_left  = r_left - 1'b1;
            n_wv    = 1'b1;
            n_waddr = r_up ? r_src + 1'b1 : r_src - IDX_W'(r_gone);
        end
        if (i_ctl.plan) begin
            if (w_up) begin
                n_src  = IDX_W'(r_count - 1'b1);
                n_left = r_count - r_first;
            end else begin
                n_src  = IDX_W'(r_first + r_nmerge);
                n_left = (r_nmerge == CNT_W'(1)) ? '0 : r_count - r_first - r_nmerge;
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_ctl.clear) begin
            n_count = '0;
        end else if (i_ctl.write) begin
            n_count = r_up ? r_count + 1'b1 : r_count - r_gone;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pv    <= 1'b0;
            r_wv    <= 1'b0;
            r_left  <= '0;
        end else begin
            r_count <= n_count;
            r_pv    <= n_pv;
            r_wv    <= n_wv;
            r_left  <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_start <= i_req.range_start;
            r_end   <= i_req.range_end_excl;
            r_ridx  <= i_req.read_index;
        end
        if (i_ctl.prep) begin
            r_lo_m1  <= r_start - 1'b1;
            r_acc_lo <= r_start;
            r_acc_hi <= r_end - 1'b1;
            r_first  <= '0;
            r_nmerge <= '0;
            r_ptr    <= '0;
        end else begin
            r_acc_lo <= n_acc_lo;
            r_acc_hi <= n_acc_hi;
            r_first  <= n_first;
            r_nmerge <= n_nmerge;
            r_ptr    <= n_ptr;
        end
        if (i_ctl.plan) begin
            r_up   <= w_up;
            r_gone <= r_nmerge - 1'b1;
        end
        r_src   <= n_src;
        r_waddr <= n_waddr;
        if (i_ctl.load_out) begin
            r_rsp.status      <= i_ctl.status;
            r_rsp.range_count <= COUNT_W'(r_count);
            r_rsp.entry_lower <= i_ctl.show_entry ? r_rdata.lower : '0;
            r_rsp.entry_upper <= i_ctl.show_entry ? r_rdata.upper : '0;
        end
    end

    assign o_rsp = r_rsp;

endmodule

// ----- hdl/iut_ctrl.sv -----
// Controller: command sequencing and handshakes for the interval union table.
module iut_ctrl import iut_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    input  logic [1:0] i_command,
    output logic       o_cmd_ready,
    output logic       o_rsp_valid,
    input  logic       i_rsp_ready,
    input  t_iut_sts   i_sts,
    output t_iut_cmd   o_ctl
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_PLAN   = 3'd3;
    localparam logic [2:0] S_MOVE   = 3'd4;
    localparam logic [2:0] S_WRITE  = 3'd5;
    localparam logic [2:0] S_RDWAIT = 3'd6;
    localparam logic [2:0] S_RESULT = 3'd7;

    logic [2:0] r_state, n_state;
    logic [1:0] r_status, n_status;
    logic       r_show, n_show;
    logic       r_rsp_valid, n_rsp_valid;
    logic       w_accept, w_load;

    assign o_cmd_ready = (r_state == S_IDLE);
    assign w_accept    = i_cmd_valid && o_cmd_ready;
    assign w_load      = (r_state == S_RESULT) && (!r_rsp_valid || i_rsp_ready);
    assign o_rsp_valid = r_rsp_valid;

    always_comb begin
        o_ctl            = '0;
        o_ctl.capture    = w_accept;
        o_ctl.clear      = w_accept && (i_command == CMD_CLEAR);
        o_ctl.prep       = (r_state == S_CHECK);
        o_ctl.scan       = (r_state == S_SCAN);
        o_ctl.plan       = (r_state == S_PLAN);
        o_ctl.move       = (r_state == S_MOVE);
        o_ctl.write      = (r_state == S_WRITE);
        o_ctl.load_out   = w_load;
        o_ctl.status     = r_status;
        o_ctl.show_entry = r_show;
    end

    always_comb begin
        n_state     = r_state;
        n_status    = r_status;
        n_show      = r_show;
        n_rsp_valid = r_rsp_valid && !i_rsp_ready;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_status = ST_OK;
                    n_show   = 1'b0;
                    case (i_command)
                        CMD_INSERT: n_state = S_CHECK;
                        CMD_READ:   n_state = S_RDWAIT;
                        default:    n_state = S_RESULT;
                    endcase
                end
            end
            S_CHECK: begin
                if (i_sts.empty) begin
                    n_status = ST_EMPTY;
                    n_state  = S_RESULT;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_PLAN;
                end
            end
            S_PLAN: begin
                if (i_sts.full) begin
                    n_status = ST_FULL;
                    n_state  = S_RESULT;
                end else begin
                    n_state = S_MOVE;
                end
            end
            S_MOVE: begin
                if (i_sts.move_done) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                n_state = S_RESULT;
            end
            S_RDWAIT: begin
                n_show   = i_sts.idx_ok;
                n_status = i_sts.idx_ok ? ST_OK : ST_BAD_INDEX;
                n_state  = S_RESULT;
            end
            S_RESULT: begin
                if (w_load) begin
                    n_rsp_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_status    <= ST_OK;
            r_show      <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_status    <= n_status;
            r_show      <= n_show;
            r_rsp_valid <= n_rsp_valid;
        end
    end

endmodule

// ----- hdl/interval_union_table.sv -----
// Interval union table: sorted disjoint range list with merge-on-insert.
//
// Request channel (i_cmd_valid / o_cmd_ready / i_cmd) carries insert, read
// and clear commands; response channel (o_rsp_valid / i_rsp_ready / o_rsp)
// returns exactly one transfer per command: status, range count after the
// command, and the entry read (zero unless a read hit a stored entry).
// One command is in flight at a time; o_cmd_ready is high only when idle.
// Steps per command, with N stored ranges: clear and an unused code go straight
// to the result step; a read adds an index check; an empty insert stops after
// its range check; an insert scans all N stored ranges, then moves up to N
// entries one at a time through the one-read/one-write table before it writes
// the merged entry. The next command is taken in the cycle after the response
// register loads.
// The response sits in an output register; a stalled receiver holds it there
// while the next command is already accepted and worked on, and that command
// waits at its final step until the register frees up.
// Reset (synchronous, active low) empties the table and drops any pending
// response. The table memory itself is not cleared; the count guards it.
module interval_union_table import iut_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cmd_valid,
    output logic     o_cmd_ready,
    input  t_iut_req i_cmd,
    output logic     o_rsp_valid,
    input  logic     i_rsp_ready,
    output t_iut_rsp o_rsp
);

    t_iut_cmd w_ctl;
    t_iut_sts w_sts;

    iut_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd_valid),
        .i_command   (i_cmd.command),
        .o_cmd_ready (o_cmd_ready),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .i_sts       (w_sts),
        .o_ctl       (w_ctl)
    );

    iut_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_cmd),
        .i_ctl   (w_ctl),
        .o_sts   (w_sts),
        .o_rsp   (o_rsp)
    );

    // one command at a time: a transfer in drops ready for the next cycle
    a_single_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd_valid && o_cmd_ready) |=> !o_cmd_ready)
        else $error("request accepted while a command is in flight");

    // a failed read never leaks table contents
    a_bad_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && (o_rsp.status == ST_BAD_INDEX)) |->
        ((o_rsp.entry_lower == '0) && (o_rsp.entry_upper == '0)))
        else $error("out-of-range read returned nonzero entry");

    // a dropped range means the table was full
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && (o_rsp.status == ST_FULL)) |->
        (o_rsp.range_count == COUNT_W'(MAX_RANGES)))
        else $error("range dropped while table not full");

    // scan and shift never share the table read port
    a_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ctl.scan && w_ctl.move))
        else $error("scan and move active together");

    a_reset_rsp: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp_valid)
        else $error("response valid right after reset");

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the interval union table: directed and random commands.
`timescale 1ns / 1ps

module tb_top import iut_pkg::*; ();

    localparam logic [1:0] CMD_UNUSED      = 2'd3;
    localparam int         DIRECTED_ITEMS  = 25;
    localparam int         RANDOM_ITEMS    = 1200 - DIRECTED_ITEMS;
    localparam int         FILL_SLOTS      = MAX_RANGES + 6;
    localparam int         HOLD_CYCLES     = 300;
    localparam int         WATCHDOG_LIMIT  = 4000;
    localparam int         TAIL_CYCLES     = 200;

    // Tracks the expected sorted range list and the queue of pending responses.
    class range_scoreboard;
        logic [ADDR_W-1:0] lo_tab [MAX_RANGES];
        logic [ADDR_W-1:0] hi_tab [MAX_RANGES];
        int unsigned       n_ranges;
        int unsigned       peak_ranges;
        t_iut_rsp          expected_q [$];
        int unsigned       n_cmds;
        int unsigned       n_checked;
        int unsigned       errors;
        int unsigned       status_seen [4];

        function new();
            n_ranges    = 0;
            peak_ranges = 0;
            n_cmds      = 0;
            n_checked   = 0;
            errors      = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        // Inserts lo..hi (inclusive), absorbing overlapping or adjacent entries.
        function logic [1:0] merge_range(logic [ADDR_W-1:0] lo, logic [ADDR_W-1:0] hi);
            int unsigned first, last, gone, k;
            first = 0;
            while (first < n_ranges && lo != '0 && hi_tab[first] < lo - 64'd1)
                first++;
            last = first;
            while (last < n_ranges &&
                   !(hi != {ADDR_W{1'b1}} && lo_tab[last] > hi + 64'd1))
                last++;
            if (last > first) begin
                if (lo_tab[first] < lo)
                    lo = lo_tab[first];
                if (hi_tab[last-1] > hi)
                    hi = hi_tab[last-1];
                lo_tab[first] = lo;
                hi_tab[first] = hi;
                gone = last - first - 1;
                if (gone != 0) begin
                    for (k = last; k < n_ranges; k++) begin
                        lo_tab[k-gone] = lo_tab[k];
                        hi_tab[k-gone] = hi_tab[k];
                    end
                    n_ranges -= gone;
                end
                return ST_OK;
            end
            if (n_ranges >= MAX_RANGES)
                return ST_FULL;
            for (k = n_ranges; k > first; k--) begin
                lo_tab[k] = lo_tab[k-1];
                hi_tab[k] = hi_tab[k-1];
            end
            lo_tab[first] = lo;
            hi_tab[first] = hi;
            n_ranges++;
            if (n_ranges > peak_ranges)
                peak_ranges = n_ranges;
            return ST_OK;
        endfunction

        function void note_command(t_iut_req req);
            t_iut_rsp rsp;
            rsp = '0;
            case (req.command)
                CMD_INSERT: begin
                    if (req.range_end_excl <= req.range_start)
                        rsp.status = ST_EMPTY;
                    else
                        rsp.status = merge_range(req.range_start, req.range_end_excl - 64'd1);
                end
                CMD_READ: begin
                    if (req.read_index < n_ranges) begin
                        rsp.entry_lower = lo_tab[req.read_index];
                        rsp.entry_upper = hi_tab[req.read_index];
                    end else begin
                        rsp.status = ST_BAD_INDEX;
                    end
                end
                CMD_CLEAR: n_ranges = 0;
                default: ;
            endcase
            rsp.range_count = COUNT_W'(n_ranges);
            status_seen[rsp.status]++;
            n_cmds++;
            expected_q = {expected_q, rsp};
        endfunction

        function void check_field(string what, logic [ADDR_W-1:0] want,
                                  logic [ADDR_W-1:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
                errors++;
            end
        endfunction

        function void check_response(t_iut_rsp got);
            t_iut_rsp want;
            if (expected_q.size() == 0) begin
                $display("%0t: response with nothing outstanding: %h", $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            n_checked++;
            check_field("status", ADDR_W'(want.status), ADDR_W'(got.status));
            check_field("range_count", ADDR_W'(want.range_count), ADDR_W'(got.range_count));
            check_field("entry_lower", want.entry_lower, got.entry_lower);
            check_field("entry_upper", want.entry_upper, got.entry_upper);
        endfunction
    endclass

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     cmd_valid = 1'b0;
    logic     cmd_ready;
    t_iut_req cmd_bus   = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    t_iut_rsp rsp_bus;

    logic     hold_req  = 1'b0;
    logic     hold_ack  = 1'b0;
    int       hold_left = 0;
    int       recv_stall_pct = 0;
    int       send_idle_pct  = 0;
    int       quiet_cycles   = 0;

    range_scoreboard sb;

    interval_union_table uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd_bus),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp       (rsp_bus)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // Response side: random stalls plus an occasional long hold-off.
    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_ready <= 1'b0;
        end else begin
            if (rsp_valid && rsp_ready)
                sb.check_response(rsp_bus);
            if (hold_req != hold_ack) begin
                hold_ack  <= hold_req;
                hold_left <= HOLD_CYCLES;
                rsp_ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                rsp_ready <= 1'b0;
            end else begin
                rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer in %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_iut_req noise_req();
        t_iut_req r;
        r.command        = 2'($urandom_range(3));
        r.range_start    = {$urandom, $urandom};
        r.range_end_excl = {$urandom, $urandom};
        r.read_index     = 6'($urandom_range(63));
        return r;
    endfunction

    task automatic send_cmd(input t_iut_req req);
        int unsigned idle;
        idle = 0;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
            idle++;
        if (idle != 0) begin
            cmd_valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_bus   <= req;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        sb.note_command(req);
    endtask

    task automatic send_range(input logic [ADDR_W-1:0] start, input logic [ADDR_W-1:0] stop);
        t_iut_req r;
        r = noise_req();
        r.command        = CMD_INSERT;
        r.range_start    = start;
        r.range_end_excl = stop;
        send_cmd(r);
    endtask

    task automatic send_read(input logic [RIDX_W-1:0] idx);
        t_iut_req r;
        r = noise_req();
        r.command    = CMD_READ;
        r.read_index = idx;
        send_cmd(r);
    endtask

    task automatic send_plain(input logic [1:0] code);
        t_iut_req r;
        r = noise_req();
        r.command = code;
        send_cmd(r);
    endtask

    // Sender stops and waits until every outstanding response is back.
    task automatic drain_responses();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    task automatic run_directed();
        send_read(6'd0);
        send_range(64'd5, 64'd5);
        send_range(64'd7, 64'd3);
        send_range(64'd0, 64'd0);
        send_range(64'd0, 64'd1);
        send_range({ADDR_W{1'b1}} - 64'd1, {ADDR_W{1'b1}});
        send_range(64'd10, 64'd20);
        send_range(64'd21, 64'd30);
        send_range(64'd20, 64'd21);     // bridges the two neighbors
        send_range(64'd2, 64'd4);
        send_range(64'd1, 64'd2);       // touches both sides
        send_range(64'd30, 64'd31);
        send_range(64'd5, 64'd9);
        send_range(64'd4, 64'd10);      // swallows three entries
        send_read(6'd0);
        send_read(6'd1);
        send_read(6'd63);
        send_plain(CMD_UNUSED);
        send_range({ADDR_W{1'b1}} - 64'd99, {ADDR_W{1'b1}});
        send_read(6'd1);
        send_plain(CMD_CLEAR);
        send_read(6'd0);
        send_range(64'd0, {ADDR_W{1'b1}});
        send_read(6'd0);
        send_range({ADDR_W{1'b1}}, {ADDR_W{1'b1}});
    endtask

    // Fill to capacity with separated ranges, overflow, then merge some back.
    task automatic fill_table(input logic [ADDR_W-1:0] base);
        int unsigned slot_ord [FILL_SLOTS];
        int unsigned i, j, tmp, a, b;
        for (i = 0; i < FILL_SLOTS; i++)
            slot_ord[i] = i;
        for (i = FILL_SLOTS - 1; i > 0; i--) begin
            j           = $urandom_range(i);
            tmp         = slot_ord[i];
            slot_ord[i] = slot_ord[j];
            slot_ord[j] = tmp;
        end
        send_plain(CMD_CLEAR);
        // slots are 3 apart and at most 2 wide, so none touch
        for (i = 0; i < FILL_SLOTS; i++)
            send_range(base + 64'(3 * slot_ord[i]),
                       base + 64'(3 * slot_ord[i] + $urandom_range(1, 2)));
        repeat (4) send_read(6'($urandom_range(63)));
        a = $urandom_range(FILL_SLOTS - 2);
        send_range(base + 64'(3 * a + 2), base + 64'(3 * a + 3));
        a = $urandom_range(FILL_SLOTS - 10);
        b = a + $urandom_range(1, 8);
        send_range(base + 64'(3 * a), base + 64'(3 * b + 1));
        send_range(base + 64'(3 * FILL_SLOTS + 5), base + 64'(3 * FILL_SLOTS + 7));
        repeat (4) send_read(6'($urandom_range(63)));
    endtask

    task automatic cluster_item(input logic [ADDR_W-1:0] base, input int unsigned span);
        t_iut_req          r;
        int unsigned       pick, len;
        logic [ADDR_W-1:0] tmp;
        r    = noise_req();
        pick = $urandom_range(99);
        if (pick < 60) begin
            r.command        = CMD_INSERT;
            len              = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 6);
            r.range_start    = base + 64'($urandom_range(span));
            r.range_end_excl = r.range_start + 64'(len);
            if ($urandom_range(29) == 0) begin
                tmp              = r.range_start;
                r.range_start    = r.range_end_excl;
                r.range_end_excl = tmp;
            end
        end else if (pick < 85) begin
            r.command = CMD_READ;
            if (sb.n_ranges != 0 && $urandom_range(3) != 0)
                r.read_index = 6'($urandom_range(sb.n_ranges - 1));
        end else if (pick < 92) begin
            r.command = CMD_INSERT;
        end else if (pick < 97) begin
            r.command = CMD_UNUSED;
        end else begin
            r.command = CMD_CLEAR;
        end
        send_cmd(r);
    endtask

    task automatic run_random();
        int unsigned       seq_no, first_cmd, span;
        logic [ADDR_W-1:0] base;
        seq_no    = 0;
        first_cmd = sb.n_cmds;
        while (sb.n_cmds - first_cmd < RANDOM_ITEMS) begin
            case (seq_no % 4)
                0: set_idling(0, 0);
                1: set_idling(45, 0);
                2: set_idling(0, 45);
                default: set_idling(31, 31);
            endcase
            span = $urandom_range(40, 400);
            case ($urandom_range(2))
                0: base = '0;
                1: base = {ADDR_W{1'b1}} - 64'(span);
                default: base = {$urandom, $urandom};
            endcase
            // long receiver hold while the sender keeps pushing
            if (seq_no % 8 == 4)
                hold_req <= ~hold_req;
            if ($urandom_range(99) < 20) begin
                if (base > {ADDR_W{1'b1}} - 64'(3 * FILL_SLOTS + 8))
                    base = {ADDR_W{1'b1}} - 64'(3 * FILL_SLOTS + 8);
                fill_table(base);
            end else begin
                repeat ($urandom_range(30, 70)) cluster_item(base, span);
            end
            if (seq_no % 5 == 2 || $urandom_range(9) < 3)
                drain_responses();
            seq_no++;
        end
    endtask

    initial begin
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        run_directed();
        run_random();
        drain_responses();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Ran %0d commands under four flow-control mixes; peak table use %0d of %0d",
                 sb.n_cmds, sb.peak_ranges, MAX_RANGES);
        $display("Statuses: %0d ok, %0d empty, %0d dropped full, %0d bad index; %0d errors",
                 sb.status_seen[ST_OK], sb.status_seen[ST_EMPTY], sb.status_seen[ST_FULL],
                 sb.status_seen[ST_BAD_INDEX], sb.errors);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
